// ===== design/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants of the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

	localparam int unsigned NUM_DIGITS  = 10;
	localparam int unsigned DIG_IDX_W   = 4;
	localparam int unsigned MAG_W       = 32;
	localparam int unsigned THR_W       = 34;
	localparam int unsigned CHAR_W      = 6;

	localparam logic [DIG_IDX_W-1:0] TOP_DIG_IDX = DIG_IDX_W'(NUM_DIGITS - 1);
	localparam logic [CHAR_W-1:0]    CH_ZERO     = 6'd48;
	localparam logic [CHAR_W-1:0]    CH_MINUS    = 6'd45;

	typedef logic [DIG_IDX_W-1:0] dig_idx_t;
	typedef logic [3:0]           digit_t;

	typedef struct packed {
		logic     load;
		logic     step;
		dig_idx_t idx;
	} sida_cmd_t;

	typedef struct packed {
		logic   in_neg;
		digit_t digit;
	} sida_status_t;

	function automatic logic [THR_W-1:0] pow10(input dig_idx_t k);
		logic [THR_W-1:0] p;
		unique case (k)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== design/sida_datapath.sv =====
// ----------------------------------------------------------------------------
// sida_datapath
// Holds the magnitude and extracts one decimal digit per step, from the most
// significant place down, by comparing against the nine multiples of the
// current power of ten and subtracting the largest one that fits.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_datapath (
	input  wire logic                  clk,
	input  wire logic [31:0]           value,
	input  wire sida_pkg::sida_cmd_t   cmd,
	output sida_pkg::sida_status_t     status
);
	import sida_pkg::*;

	logic [MAG_W-1:0] mag_q;
	logic [THR_W-1:0] pw;
	logic [THR_W-1:0] thr [NUM_DIGITS];
	digit_t           digit;

	always_comb begin
		pw     = pow10(cmd.idx);
		thr[0] = '0;
		digit  = '0;
		for (int j = 1; j < NUM_DIGITS; j++) begin
			thr[j] = pw * THR_W'(j);
		end
		for (int j = 1; j < NUM_DIGITS; j++) begin
			if ({2'b00, mag_q} >= thr[j]) begin
				digit = 4'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value[31] ? (~value + 32'd1) : value;
		end else if (cmd.step) begin
			mag_q <= mag_q - thr[digit][MAG_W-1:0];
		end
	end

	assign status.in_neg = value[31];
	assign status.digit  = digit;

endmodule

`default_nettype wire

// ===== design/sida_ctrl.sv =====
// ----------------------------------------------------------------------------
// sida_ctrl
// Sequencer of the converter: emits the sign, walks the ten decimal places,
// suppresses leading zeros and drives the registered result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire sida_pkg::sida_status_t status,
	output sida_pkg::sida_cmd_t         cmd,
	output logic                        strobe,
	output logic [5:0]                  char_code,
	output logic                        last
);
	import sida_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t              state_q;
	dig_idx_t            idx_q;
	logic                started_q;
	logic                strobe_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic                emit;

	assign busy     = (state_q != ST_IDLE);
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.step = (state_q == ST_DIGIT);
	assign cmd.idx  = idx_q;
	assign emit     = (status.digit != '0) || started_q || (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			started_q <= 1'b0;
			strobe_q  <= 1'b0;
			char_q    <= '0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					strobe_q <= 1'b0;
					last_q   <= 1'b0;
					if (start) begin
						idx_q     <= TOP_DIG_IDX;
						started_q <= 1'b0;
						state_q   <= status.in_neg ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					char_q   <= CH_MINUS;
					last_q   <= 1'b0;
					state_q  <= ST_DIGIT;
				end
				ST_DIGIT: begin
					strobe_q  <= emit;
					char_q    <= CH_ZERO + {2'b00, status.digit};
					last_q    <= (idx_q == '0);
					started_q <= started_q | emit;
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q - dig_idx_t'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

`ifndef SYNTH
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> (state_q == ST_IDLE))
		else $error("final character shown while the sequencer is still busy");

	a_units_always_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT && idx_q == '0) |=> (strobe_q && last_q))
		else $error("units place did not produce the final character");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start the sequencer");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && char_q == CH_MINUS) |-> !last_q)
		else $error("minus sign flagged as final character");

	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT) |-> (status.digit <= 4'd9))
		else $error("extracted digit out of decimal range");
`endif

endmodule

`default_nettype wire

// ===== design/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a 32-bit two's complement integer to its decimal ASCII characters.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its characters then
// appear most significant first, each for one cycle with strobe high: a
// leading '-' for a negative value, then the digits without leading zeros,
// the final one with last high. The receiver cannot stall the block, so the
// results must be taken as they come. The core scans all ten decimal places,
// one place per cycle in a shared compare-and-subtract unit, plus a sign
// step for a negative value, and busy stays high until the units place is
// done; a new item can be taken as soon as busy is low again.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] value,
	output logic             strobe,
	output logic [5:0]       char_code,
	output logic             last
);
	import sida_pkg::*;

	sida_cmd_t    cmd;
	sida_status_t status;

	sida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.status    (status),
		.cmd       (cmd),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last)
	);

	sida_datapath u_datapath (
		.clk    (clk),
		.value  (value),
		.cmd    (cmd),
		.status (status)
	);

endmodule

`default_nettype wire
